>>> hw/rtl/assert_macros.svh
// Assertion macros used by the allocator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is held.
`define GTSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GTSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/gtsa_pkg.sv
package gtsa_pkg;

    // Table size and the widths that follow from it.
    localparam int SLOTS   = 64;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int SLOT_CW = SLOT_AW + 1;

    // Handle layout: generation in the upper bits, slot index below.
    localparam int HANDLE_W     = 32;
    localparam int SLOT_FIELD_W = 20;
    localparam int GEN_W        = 12;

    // Configuration register.
    localparam int             CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam int STATUS_W = 2;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ORPHAN = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL_RD,
        ST_REL_CHK,
        ST_DONE
    } t_state;

    // Access to the generation store.
    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] waddr;
        logic [GEN_W-1:0]   wdata;
        logic               re;
        logic [SLOT_AW-1:0] raddr;
    } t_mem_req;

    // One finished result.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        t_status             status;
    } t_result;

endpackage

>>> hw/rtl/gtsa_gen_mem.sv
module gtsa_gen_mem
    import gtsa_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_req         i_req,
    output logic [GEN_W-1:0] o_rdata
);

    // Generation stamp of each slot; read for the slot that a release names, in use or not.
    logic [GEN_W-1:0] mem [SLOTS];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

>>> hw/rtl/gtsa_ctrl.sv
`include "assert_macros.svh"

module gtsa_ctrl
    import gtsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_opcode             i_opcode,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [SLOT_CW-1:0]  i_lim,
    output t_mem_req            o_mem_req,
    input  logic [GEN_W-1:0]    i_rdata,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_result             o_res
);

    t_state               r_state, n_state;
    logic [SLOTS-1:0]     r_used;
    logic [SLOT_CW-1:0]   r_idx;
    logic                 r_pass;
    logic [GEN_W-1:0]     r_gen;
    logic [SLOT_CW-1:0]   r_scan_start;
    logic [HANDLE_W-1:0]  r_handle;
    t_result              r_res;

    logic                 accept;
    logic                 idx_in_lim;
    logic                 slot_free;
    logic                 found;
    logic                 rel_ok;
    logic [SLOT_AW-1:0]   idx_addr;
    logic [SLOT_AW-1:0]   rel_addr;

    assign accept   = i_in_valid && o_in_ready;
    assign idx_addr = r_idx[SLOT_AW-1:0];
    assign rel_addr = r_handle[SLOT_AW-1:0];

    // The scan compare unit: one slot is tested against the limit per cycle.
    assign idx_in_lim = r_idx < i_lim;
    assign slot_free  = !r_used[idx_addr];
    assign found      = idx_in_lim && slot_free;

    // A release is good when the slot is in range, occupied and stamped alike.
    assign rel_ok = (r_handle[SLOT_FIELD_W-1:0] < SLOT_FIELD_W'(i_lim))
                 && r_used[rel_addr]
                 && (i_rdata == r_handle[HANDLE_W-1 -: GEN_W]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_RELEASE) ? ST_REL_RD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (found || (!idx_in_lim && r_pass)) begin
                    n_state = ST_DONE;
                end
            end
            ST_REL_RD:  n_state = ST_REL_CHK;
            ST_REL_CHK: n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_ready        = 1'b0;
        o_res_valid       = 1'b0;
        o_mem_req.we      = 1'b0;
        o_mem_req.waddr   = idx_addr;
        o_mem_req.wdata   = r_gen;
        o_mem_req.re      = 1'b0;
        o_mem_req.raddr   = rel_addr;
        unique case (r_state)
            ST_IDLE:    o_in_ready   = 1'b1;
            ST_SCAN:    o_mem_req.we = found;
            ST_REL_RD:  o_mem_req.re = 1'b1;
            ST_REL_CHK: ;
            ST_DONE:    o_res_valid  = 1'b1;
            default:    ;
        endcase
    end

    assign o_res = r_res;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= '0;
            r_gen        <= '0;
            r_scan_start <= '0;
            r_pass       <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_pass <= 1'b0;
                end
                ST_SCAN: begin
                    if (found) begin
                        r_used[idx_addr] <= 1'b1;
                        r_scan_start     <= r_idx + SLOT_CW'(1);
                    end else if (!idx_in_lim && !r_pass) begin
                        // First pass ran out: next generation, scan again from zero.
                        r_gen  <= r_gen + GEN_W'(1);
                        r_pass <= 1'b1;
                    end
                end
                ST_REL_CHK: begin
                    if (rel_ok) begin
                        r_used[rel_addr] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Scan index, request handle and result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_idx    <= r_scan_start;
                    r_handle <= i_handle;
                end
            end
            ST_SCAN: begin
                if (found) begin
                    r_res.handle <= {r_gen, SLOT_FIELD_W'(r_idx)};
                    r_res.status <= STAT_OK;
                end else if (idx_in_lim) begin
                    r_idx <= r_idx + SLOT_CW'(1);
                end else if (!r_pass) begin
                    r_idx <= '0;
                end else begin
                    r_res.handle <= '0;
                    r_res.status <= STAT_FULL;
                end
            end
            ST_REL_CHK: begin
                r_res.handle <= r_handle;
                r_res.status <= rel_ok ? STAT_OK : STAT_ORPHAN;
            end
            default: ;
        endcase
    end

    `GTSA_ASSERT(a_alloc_marks_used, i_clk, i_rst_n, (r_state == ST_SCAN && found) |=> r_used[$past(idx_addr)], "allocated slot not marked used")
    `GTSA_ASSERT(a_release_frees, i_clk, i_rst_n, (r_state == ST_REL_CHK && rel_ok) |=> !r_used[$past(rel_addr)], "released slot still marked used")
    `GTSA_ASSERT(a_full_handle_zero, i_clk, i_rst_n, (r_state == ST_DONE && r_res.status == STAT_FULL) |-> (r_res.handle == '0 && r_pass), "table full result malformed")
    `GTSA_ASSERT_ALWAYS(a_idx_bound, i_clk, (r_state == ST_SCAN) |-> (32'(r_idx) <= 32'(SLOTS)), "scan index beyond table")

endmodule

>>> hw/rtl/generation_tagged_slot_allocator_unit.sv
// Channel   | Direction | tdata                  | tuser
// ----------+-----------+------------------------+------------------------
// s_axis    | in        | handle_in [31:0]       | opcode [0]
// m_axis    | out       | handle_out [31:0]      | status [1:0]
// cfg       | in        | active_slots [6:0]     | -
//
// An allocate request is served by a scan: the controller tests one slot per cycle,
// from the rover to the limit and, if none is free, once more from slot 0 with the
// next generation. A release request first reads the generation store, whose read port
// is registered, and then checks the stamp.
// Reset is synchronous and clears all slot flags, the rover and the generation at once;
// the generation store is not cleared. A stalled result waits in the output register.
module generation_tagged_slot_allocator_unit
    import gtsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [HANDLE_W-1:0] s_axis_tdata,   // handle_in [31:0]
    input  logic                s_axis_tuser,   // opcode [0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [HANDLE_W-1:0] m_axis_tdata,   // handle_out [31:0]
    output logic [STATUS_W-1:0] m_axis_tuser,   // status [1:0]
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    logic [CFG_W-1:0]    r_active;
    logic [SLOT_CW-1:0]  lim;
    t_mem_req            mem_req;
    logic [GEN_W-1:0]    mem_rdata;
    logic                res_valid;
    logic                res_ready;
    t_result             res;
    logic                r_out_valid;
    t_result             r_out;

    // Allocation limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // The limit is clamped to the table size.
    assign lim = (32'(r_active) > 32'(SLOTS)) ? SLOT_CW'(SLOTS) : SLOT_CW'(r_active);

    gtsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (t_opcode'(s_axis_tuser)),
        .i_handle    (s_axis_tdata),
        .i_lim       (lim),
        .o_mem_req   (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    gtsa_gen_mem u_gen_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.handle;
    assign m_axis_tuser  = r_out.status;

endmodule

>>> tb/generation_tagged_slot_allocator_unit_test.sv
module generation_tagged_slot_allocator_unit_test;
    import gtsa_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE       = 16;
    localparam int GEN_BUMPS    = 24;

    // Clock, reset and the block's inputs, all known from the start.
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [HANDLE_W-1:0] s_axis_tdata  = '0;   // handle_in [31:0]
    logic                s_axis_tuser  = 1'b0; // opcode [0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [HANDLE_W-1:0] m_axis_tdata;         // handle_out [31:0]
    logic [STATUS_W-1:0] m_axis_tuser;         // status [1:0]
    logic                i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata   = '0;

    // Shadow copy of the allocator state.
    logic               mdl_used        [SLOTS];
    logic [GEN_W-1:0]   mdl_gen         [SLOTS];
    logic               mdl_gen_written [SLOTS];
    logic [SLOT_CW-1:0] mdl_rover;
    logic [GEN_W-1:0]   mdl_generation;
    logic [CFG_W-1:0]   mdl_active;

    // Results still owed by the block, oldest first.
    t_result pending_results[$];

    int  fail_count      = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  full_seen       = 0;
    int  orphan_seen     = 0;
    int  cycle_count     = 0;
    bit  tx_idle_en      = 1'b0;
    bit  rx_idle_en      = 1'b0;
    int  rx_hold_cycles  = 0;

    generation_tagged_slot_allocator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // First free slot in [from, lim), or lim when there is none.
    function automatic int first_free_slot(input int from, input int lim);
        for (int i = from; i < lim; i++) begin
            if (!mdl_used[i]) begin
                return i;
            end
        end
        return lim;
    endfunction

    // Works out the response to one request and advances the shadow state.
    function automatic t_result predict_handle_request(input t_opcode op,
                                                       input logic [HANDLE_W-1:0] h);
        t_result                 r;
        int                      lim;
        int                      s;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [GEN_W-1:0]        g;
        lim = (int'(mdl_active) < SLOTS) ? int'(mdl_active) : SLOTS;
        if (op == OP_ALLOC) begin
            s = first_free_slot(int'(mdl_rover), lim);
            if (s >= lim) begin
                mdl_generation = mdl_generation + 1'b1;
                s = first_free_slot(0, lim);
            end
            if (s >= lim) begin
                r.handle = '0;
                r.status = STAT_FULL;
            end else begin
                mdl_used[s]        = 1'b1;
                mdl_gen[s]         = mdl_generation;
                mdl_gen_written[s] = 1'b1;
                mdl_rover          = SLOT_CW'(s + 1);
                r.handle           = {mdl_generation, SLOT_FIELD_W'(s)};
                r.status           = STAT_OK;
            end
        end else begin
            slot     = h[SLOT_FIELD_W-1:0];
            g        = h[HANDLE_W-1:SLOT_FIELD_W];
            r.handle = h;
            if (slot < lim && mdl_used[slot[SLOT_AW-1:0]] &&
                mdl_gen[slot[SLOT_AW-1:0]] == g) begin
                mdl_used[slot[SLOT_AW-1:0]] = 1'b0;
                r.status = STAT_OK;
            end else begin
                r.status = STAT_ORPHAN;
            end
        end
        return r;
    endfunction

    // The handle that currently owns a slot.
    function automatic logic [HANDLE_W-1:0] owner_handle(input int slot);
        return {mdl_gen[slot], SLOT_FIELD_W'(slot)};
    endfunction

    // Keeps a release away from generation entries that were never written.
    function automatic logic [HANDLE_W-1:0] written_alias(input logic [HANDLE_W-1:0] h);
        logic [HANDLE_W-1:0] r;
        r = h;
        if (!mdl_gen_written[h[SLOT_AW-1:0]]) begin
            r[SLOT_AW-1:0] = '0;
        end
        return r;
    endfunction

    // Offers one request, waits for it to be taken and records the response owed.
    task automatic send_request(input t_opcode op, input logic [HANDLE_W-1:0] h,
                                output t_result res);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        res = predict_handle_request(op, h);
        pending_results.push_back(res);
        requests_sent++;
    endtask

    // Stops offering and waits until every owed response has arrived.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_active_slots(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mdl_active  = value;
    endtask

    // Receiver: ready with random stalls, or one long hold when asked for.
    initial begin : receiver
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Each response taken is compared with the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected response, expected none, actual handle %h status %0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.status == STAT_FULL) full_seen++;
                if (want.status == STAT_ORPHAN) orphan_seen++;
                if (m_axis_tdata !== want.handle) begin
                    fail_count++;
                    $display("%0t: handle mismatch, expected %h, actual %h",
                             $time, want.handle, m_axis_tdata);
                end
                if (m_axis_tuser !== want.status) begin
                    fail_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_axis_tuser);
                end
            end
        end
    end

    // Fresh table: handles come out in slot order with generation zero.
    task automatic test_first_allocations();
        t_result res;
        write_active_slots(CFG_RESET);
        repeat (3) send_request(OP_ALLOC, '0, res);
        wait_all_results();
    endtask

    // Releases: a good one, then a free slot, a wrong generation, out of range slots; then an allocate.
    task automatic test_release_checks();
        t_result res;
        send_request(OP_RELEASE, owner_handle(1), res);
        send_request(OP_RELEASE, owner_handle(1), res);
        send_request(OP_RELEASE, {12'd1, 20'd0}, res);
        send_request(OP_RELEASE, {12'd0, 20'h80000}, res);
        send_request(OP_RELEASE, {12'd0, 20'h00040}, res);
        send_request(OP_ALLOC, '1, res);
        wait_all_results();
    endtask

    // Two slots: rover past the limit, a full table, a used slot above the limit.
    task automatic test_small_limit();
        t_result res;
        write_active_slots(7'd2);
        send_request(OP_ALLOC, '0, res);
        send_request(OP_ALLOC, '0, res);
        send_request(OP_RELEASE, owner_handle(2), res);
        send_request(OP_RELEASE, owner_handle(1), res);
        wait_all_results();
    endtask

    // A limit of zero reports full; a limit above the table is clamped.
    task automatic test_zero_and_clamped_limit();
        t_result res;
        write_active_slots(7'd0);
        send_request(OP_ALLOC, '0, res);
        send_request(OP_RELEASE, owner_handle(0), res);
        wait_all_results();
        write_active_slots(7'd127);
        send_request(OP_ALLOC, '0, res);
        send_request(OP_RELEASE, {12'hFFF, 20'hFFFC0}, res);
        wait_all_results();
        write_active_slots(CFG_RESET);
    endtask

    // One slot kept busy: each allocate reports full and moves the generation on.
    task automatic test_generation_bump();
        t_result res;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_active_slots(7'd1);
        if (!mdl_used[0]) begin
            send_request(OP_ALLOC, '0, res);
        end
        repeat (GEN_BUMPS) begin
            send_request(OP_ALLOC, '0, res);
        end
        send_request(OP_RELEASE, owner_handle(0), res);
        send_request(OP_ALLOC, '0, res);
        send_request(OP_RELEASE, res.handle, res);
        wait_all_results();
        write_active_slots(CFG_RESET);
    endtask

    // The receiver holds off while requests keep coming, so the input stalls.
    task automatic test_output_backpressure();
        t_result res;
        logic [HANDLE_W-1:0] granted[$];
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        rx_hold_cycles = 300;
        repeat (5) begin
            send_request(OP_ALLOC, $urandom, res);
            if (res.status == STAT_OK) granted.push_back(res.handle);
        end
        while (granted.size() != 0) begin
            send_request(OP_RELEASE, granted.pop_front(), res);
        end
        wait_all_results();
    endtask

    // Mostly allocate and release of live handles; the rest stale or stray handles.
    task automatic test_random_traffic(input logic [CFG_W-1:0] limit, input int count,
                                       input bit idle);
        t_result             res;
        int                  pick;
        int                  lim;
        int                  start;
        int                  slot;
        logic [HANDLE_W-1:0] h;
        write_active_slots(limit);
        tx_idle_en = idle;
        rx_idle_en = idle;
        lim = (int'(limit) < SLOTS) ? int'(limit) : SLOTS;
        repeat (count) begin
            pick  = $urandom_range(0, 99);
            start = $urandom_range(0, SLOTS - 1);
            slot  = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot < 0 && mdl_used[(start + i) % SLOTS]) slot = (start + i) % SLOTS;
            end
            if (pick < 45 || (pick < 88 && slot < 0)) begin
                send_request(OP_ALLOC, $urandom, res);
            end else if (pick < 80) begin
                send_request(OP_RELEASE, owner_handle(slot), res);
            end else if (pick < 88) begin
                h = owner_handle(slot);
                h[HANDLE_W-1:SLOT_FIELD_W] ^= GEN_W'($urandom_range(1, (1 << GEN_W) - 1));
                send_request(OP_RELEASE, h, res);
            end else if (pick < 94) begin
                h = {GEN_W'($urandom), SLOT_FIELD_W'($urandom_range(lim, 20'hFFFFF))};
                send_request(OP_RELEASE, written_alias(h), res);
            end else begin
                send_request(OP_RELEASE, written_alias($urandom), res);
            end
        end
        wait_all_results();
    endtask

    initial begin : main
        for (int i = 0; i < SLOTS; i++) begin
            mdl_used[i]        = 1'b0;
            mdl_gen[i]         = '0;
            mdl_gen_written[i] = 1'b0;
        end
        mdl_rover      = '0;
        mdl_generation = '0;
        mdl_active     = CFG_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_allocations();
        test_release_checks();
        test_small_limit();
        test_zero_and_clamped_limit();
        test_generation_bump();
        test_output_backpressure();
        test_random_traffic(7'd64, 150, 1'b1);
        test_random_traffic(7'd1, 80, 1'b1);
        test_random_traffic(7'd8, 120, 1'b1);
        test_random_traffic(7'd33, 120, 1'b1);
        test_random_traffic(7'd127, 120, 1'b1);
        test_random_traffic(7'd2, 100, 1'b1);
        test_random_traffic(7'd64, 110, 1'b0);

        $display("Sent %0d requests and checked %0d responses (%0d table full, %0d orphaned).",
                 requests_sent, results_checked, full_seen, orphan_seen);
        $display("Limits from zero to clamped, generation steps on a busy slot, a long output stall.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
